### rtl/kcl_pkg.sv
// Package with key codes, action and event codes and queue item type for the keypad code lock.
package kcl_pkg;

    localparam int PASS_LEN = 5;
    localparam int SYM_W = 8;
    localparam int PASS_W = PASS_LEN * SYM_W;
    localparam int OUT_COUNT_W = 5;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [PASS_W-1:0] PASS_RESET = 40'h3132333435;

    localparam logic [SYM_W-1:0] SYM_BLANK = 8'h20;
    localparam logic [SYM_W-1:0] SYM_RESET [PASS_LEN] = '{8'h6A, 8'h6A, 8'h6A, 8'h6A, 8'h00};

    localparam logic [7:0] KEY_NONE  = 8'd0;
    localparam logic [7:0] KEY_1     = 8'd252;
    localparam logic [7:0] KEY_2     = 8'd245;
    localparam logic [7:0] KEY_3     = 8'd237;
    localparam logic [7:0] KEY_PAREN = 8'd231;
    localparam logic [7:0] KEY_4     = 8'd125;
    localparam logic [7:0] KEY_5     = 8'd246;
    localparam logic [7:0] KEY_6     = 8'd219;
    localparam logic [7:0] KEY_7     = 8'd190;
    localparam logic [7:0] KEY_8     = 8'd189;
    localparam logic [7:0] KEY_9     = 8'd187;
    localparam logic [7:0] KEY_STAR  = 8'd120;
    localparam logic [7:0] KEY_0     = 8'd126;
    localparam logic [7:0] KEY_HASH  = 8'd123;
    localparam logic [7:0] KEY_CLEAR = 8'd215;
    localparam logic [7:0] KEY_BACK  = 8'd183;
    localparam logic [7:0] KEY_ENTER = 8'd119;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_CLEAR,
        ACT_BACK,
        ACT_ENTER
    } act_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_RIGHT = 2'd1,
        EVT_WRONG = 2'd2
    } event_t;

    typedef struct packed {
        act_t             act;
        logic [SYM_W-1:0] sym;
        logic             no_key;
    } item_t;

endpackage

### rtl/kcl_front.sv
// Front end: takes scan code transfers and classifies them into queue items.
module kcl_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kcl_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] raw_code
    input  logic                               q_full,
    output logic                               q_push,
    output kcl_pkg::item_t                     q_item
);

    logic [7:0] code;

    assign code     = s_tdata[7:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.act    = kcl_pkg::ACT_NONE;
        q_item.sym    = '0;
        q_item.no_key = (code == kcl_pkg::KEY_NONE);
        unique case (code)
            kcl_pkg::KEY_1: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h31;
            end
            kcl_pkg::KEY_2: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h32;
            end
            kcl_pkg::KEY_3: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h33;
            end
            kcl_pkg::KEY_PAREN: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h29;
            end
            kcl_pkg::KEY_4: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h34;
            end
            kcl_pkg::KEY_5: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h35;
            end
            kcl_pkg::KEY_6: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h36;
            end
            kcl_pkg::KEY_7: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h37;
            end
            kcl_pkg::KEY_8: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h38;
            end
            kcl_pkg::KEY_9: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h39;
            end
            kcl_pkg::KEY_STAR: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h2A;
            end
            kcl_pkg::KEY_0: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h30;
            end
            kcl_pkg::KEY_HASH: begin
                q_item.act = kcl_pkg::ACT_APPEND;
                q_item.sym = 8'h23;
            end
            kcl_pkg::KEY_CLEAR: begin
                q_item.act = kcl_pkg::ACT_CLEAR;
            end
            kcl_pkg::KEY_BACK: begin
                q_item.act = kcl_pkg::ACT_BACK;
            end
            kcl_pkg::KEY_ENTER: begin
                q_item.act = kcl_pkg::ACT_ENTER;
            end
            default: begin
                q_item.act = kcl_pkg::ACT_NONE;
            end
        endcase
    end

endmodule

### rtl/kcl_queue.sv
// Two-entry queue between the front end and the back end.
module kcl_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  kcl_pkg::item_t push_item,
    input  logic           pop,
    output kcl_pkg::item_t head_item,
    output logic           empty,
    output logic           full
);

    kcl_pkg::item_t entry0_reg, entry0_next;
    kcl_pkg::item_t entry1_reg, entry1_next;
    logic [1:0]     level_reg, level_next;

    assign head_item = entry0_reg;
    assign empty     = (level_reg == 2'd0);
    assign full      = (level_reg == 2'd2);

    always_comb begin
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        level_next  = level_reg;
        if (pop) begin
            entry0_next = entry1_reg;
        end
        case ({push, pop})
            2'b10: begin
                level_next = level_reg + 2'd1;
                if (level_reg == 2'd0) begin
                    entry0_next = push_item;
                end else begin
                    entry1_next = push_item;
                end
            end
            2'b01: begin
                level_next = level_reg - 2'd1;
            end
            2'b11: begin
                if (level_reg == 2'd1) begin
                    entry0_next = push_item;
                end else begin
                    entry1_next = push_item;
                end
            end
            default: begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 2'd0;
        end else begin
            level_reg <= level_next;
        end
    end

endmodule

### rtl/kcl_back.sv
// Back end: applies queued key actions to the lock state and registers the result.
module kcl_back #(
    parameter int MAX_ENTRY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kcl_pkg::PASS_W-1:0]          password,
    input  kcl_pkg::item_t                      head_item,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kcl_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CW = $clog2(MAX_ENTRY + 1);

    logic [kcl_pkg::SYM_W-1:0] symbols_reg [kcl_pkg::PASS_LEN];
    logic [kcl_pkg::SYM_W-1:0] symbols_next [kcl_pkg::PASS_LEN];
    logic [CW-1:0]             count_reg, count_next;
    logic                      key_held_reg, key_held_next;
    logic                      alarm_reg, alarm_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [kcl_pkg::OUT_COUNT_W-1:0] out_count_reg;
    kcl_pkg::event_t           out_event_reg, event_next;
    logic                      out_alarm_reg;
    logic                      out_taken_reg, taken_next;

    logic                      match;
    logic [CW-1:0]             count_dec;

    assign q_pop    = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_taken_reg, out_alarm_reg, out_event_reg, out_count_reg};

    always_comb begin
        logic done;
        logic [kcl_pkg::SYM_W-1:0] want;
        done  = 1'b0;
        match = 1'b1;
        for (int i = 0; i < kcl_pkg::PASS_LEN; i++) begin
            want = password[kcl_pkg::SYM_W*(kcl_pkg::PASS_LEN-1-i) +: kcl_pkg::SYM_W];
            if (!done) begin
                if (symbols_reg[i] != want) begin
                    match = 1'b0;
                    done  = 1'b1;
                end else if (want == '0) begin
                    done = 1'b1;
                end
            end
        end
    end

    assign count_dec = (count_reg == '0) ? '0 : count_reg - CW'(1);

    always_comb begin
        symbols_next  = symbols_reg;
        count_next    = count_reg;
        key_held_next = key_held_reg;
        alarm_next    = alarm_reg;
        event_next    = kcl_pkg::EVT_NONE;
        taken_next    = 1'b0;
        if (!alarm_reg) begin
            key_held_next = key_held_reg && !head_item.no_key;
            if (!key_held_next && head_item.act != kcl_pkg::ACT_NONE) begin
                taken_next    = 1'b1;
                key_held_next = 1'b1;
                unique case (head_item.act)
                    kcl_pkg::ACT_APPEND: begin
                        if (count_reg < CW'(MAX_ENTRY)) begin
                            if (count_reg < CW'(kcl_pkg::PASS_LEN)) begin
                                symbols_next[count_reg[2:0]] = head_item.sym;
                            end
                            count_next = count_reg + CW'(1);
                        end
                    end
                    kcl_pkg::ACT_CLEAR: begin
                        count_next = '0;
                        for (int i = 0; i < kcl_pkg::PASS_LEN; i++) begin
                            symbols_next[i] = kcl_pkg::SYM_BLANK;
                        end
                    end
                    kcl_pkg::ACT_BACK: begin
                        count_next = count_dec;
                        if (count_dec < CW'(kcl_pkg::PASS_LEN)) begin
                            symbols_next[count_dec[2:0]] = kcl_pkg::SYM_BLANK;
                        end
                    end
                    kcl_pkg::ACT_ENTER: begin
                        count_next = '0;
                        if (match) begin
                            event_next = kcl_pkg::EVT_RIGHT;
                            for (int i = 0; i < kcl_pkg::PASS_LEN; i++) begin
                                symbols_next[i] = kcl_pkg::SYM_BLANK;
                            end
                        end else begin
                            event_next = kcl_pkg::EVT_WRONG;
                            alarm_next = 1'b1;
                        end
                    end
                    default: begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (q_pop) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbols_reg  <= kcl_pkg::SYM_RESET;
            count_reg    <= '0;
            key_held_reg <= 1'b0;
            alarm_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (q_pop) begin
                symbols_reg  <= symbols_next;
                count_reg    <= count_next;
                key_held_reg <= key_held_next;
                alarm_reg    <= alarm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_count_reg <= kcl_pkg::OUT_COUNT_W'(count_next);
            out_event_reg <= event_next;
            out_alarm_reg <= alarm_next;
            out_taken_reg <= taken_next;
        end
    end

endmodule

### rtl/keypad_code_lock_core.sv
// A transfer goes into a queue entry; its pop registers the result and sets m_tvalid_reg.
// Throughput: one scan code per cycle unless m_tready stalls the output register.
// A two-entry queue decouples the scan decoder from the state update and output register.
// Reset: synchronous active-low aresetn clears the entry count, alarm and key latch,
// loads the entry symbols with SYM_RESET and loads the password register with "12345".
module keypad_code_lock_core #(
    parameter int MAX_ENTRY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [kcl_pkg::PASS_W-1:0]         cfg_wr_data,   // stored_password
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kcl_pkg::IN_TDATA_W-1:0]     s_tdata,       // [7:0] raw_code
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [4:0] entry_count, [6:5] event_res, [7] alarm_on, [8] key_taken, [15:9] zero
    output logic [kcl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [kcl_pkg::PASS_W-1:0] password_reg;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_empty;
    logic                       q_full;
    kcl_pkg::item_t             push_item;
    kcl_pkg::item_t             head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            password_reg <= kcl_pkg::PASS_RESET;
        end else if (cfg_wr_en) begin
            password_reg <= cfg_wr_data;
        end
    end

    kcl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    kcl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    kcl_back #(
        .MAX_ENTRY (MAX_ENTRY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .password  (password_reg),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/kcl_checker.sv
// Port-level checker for the keypad code lock and its bind to the top level.
module kcl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [kcl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_alarm_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |=> m_tdata[7])
        else $error("alarm cleared without reset");

    a_event_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6:5] != kcl_pkg::EVT_NONE |->
            m_tdata[8] && m_tdata[4:0] == '0 && m_tdata[6:5] != 2'd3)
        else $error("event without an enter key transfer");

    a_alarm_ignore: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] && m_tdata[6:5] == kcl_pkg::EVT_NONE |-> !m_tdata[8])
        else $error("key taken while alarm latched");

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
